/* hw/rtl/cosine_similarity_unit_assert.svh */
// Assertion macros for the checker of the cosine similarity unit.
`ifndef COSINE_SIMILARITY_UNIT_ASSERT_SVH
`define COSINE_SIMILARITY_UNIT_ASSERT_SVH

// Same-cycle implication, switched off while reset is high.
`define CSU_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, switched off while reset is high.
`define CSU_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// Next-cycle implication that also holds across reset.
`define CSU_ASSERT_ALWAYS_NEXT(label, clk, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

/* hw/rtl/csu_pkg.sv */
// Types and constants shared by the cosine similarity unit.
package csu_pkg;

  localparam int ELEM_W      = 16;
  localparam int PROD_W      = 2 * ELEM_W;
  localparam int ACC_W       = 48;
  localparam int ROOT_W      = ACC_W / 2;
  localparam int QUOT_W      = ELEM_W + 1;
  localparam int FRAC_SHIFT  = ELEM_W - 1;
  localparam int QUEUE_DEPTH = 2;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int STEP_W      = $clog2(ROOT_W + 1);

  typedef struct packed {
    logic signed [ACC_W-1:0] dot;
    logic        [ACC_W-1:0] norm_a;
    logic        [ACC_W-1:0] norm_b;
  } sums_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_SQRT,
    BK_MUL,
    BK_CHECK,
    BK_DIV,
    BK_DONE
  } back_state_t;

endpackage

/* hw/rtl/csu_front.sv */
// Front end: accepts element pairs, squares and multiplies them, and accumulates the sums.
module csu_front #(
  parameter int MAX_DIM = 512
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [2*csu_pkg::ELEM_W-1:0]    s_tdata,
  input  logic                            s_tlast,
  input  logic [csu_pkg::QCNT_W-1:0]      q_count,
  output logic                            push,
  output csu_pkg::sums_t                  push_data
);

  localparam int CNT_W = $clog2(MAX_DIM + 1);

  logic                              accept;
  logic [CNT_W-1:0]                  pair_count;
  logic                              s1_valid;
  logic                              s1_last;
  logic                              s1_take;
  logic signed [csu_pkg::PROD_W-1:0] p_ab;
  logic signed [csu_pkg::PROD_W-1:0] p_aa;
  logic signed [csu_pkg::PROD_W-1:0] p_bb;
  logic signed [csu_pkg::ELEM_W-1:0] elem_a;
  logic signed [csu_pkg::ELEM_W-1:0] elem_b;
  logic signed [csu_pkg::ACC_W-1:0]  dot_sum;
  logic        [csu_pkg::ACC_W-1:0]  norm_a_sum;
  logic        [csu_pkg::ACC_W-1:0]  norm_b_sum;
  logic signed [csu_pkg::ACC_W-1:0]  dot_sum_next;
  logic        [csu_pkg::ACC_W-1:0]  norm_a_sum_next;
  logic        [csu_pkg::ACC_W-1:0]  norm_b_sum_next;
  logic        [csu_pkg::QCNT_W-1:0] slots_used;

  assign elem_a = s_tdata[csu_pkg::ELEM_W-1:0];
  assign elem_b = s_tdata[2*csu_pkg::ELEM_W-1:csu_pkg::ELEM_W];

  // A last beat waiting in the product stage will claim a queue slot.
  assign slots_used = q_count + csu_pkg::QCNT_W'(s1_valid & s1_last);
  assign s_tready   = slots_used < csu_pkg::QCNT_W'(csu_pkg::QUEUE_DEPTH);
  assign accept     = s_tvalid & s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid   <= 1'b0;
      pair_count <= '0;
    end else begin
      s1_valid <= accept;
      if (accept) begin
        if (s_tlast) begin
          pair_count <= '0;
        end else if (pair_count < CNT_W'(MAX_DIM)) begin
          pair_count <= pair_count + CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_last <= s_tlast;
      s1_take <= pair_count < CNT_W'(MAX_DIM);
      p_ab    <= elem_a * elem_b;
      p_aa    <= elem_a * elem_a;
      p_bb    <= elem_b * elem_b;
    end
  end

  always_comb begin
    dot_sum_next    = dot_sum;
    norm_a_sum_next = norm_a_sum;
    norm_b_sum_next = norm_b_sum;
    if (s1_take) begin
      dot_sum_next    = dot_sum + csu_pkg::ACC_W'(p_ab);
      norm_a_sum_next = norm_a_sum + csu_pkg::ACC_W'(unsigned'(p_aa));
      norm_b_sum_next = norm_b_sum + csu_pkg::ACC_W'(unsigned'(p_bb));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dot_sum    <= '0;
      norm_a_sum <= '0;
      norm_b_sum <= '0;
    end else if (s1_valid) begin
      if (s1_last) begin
        dot_sum    <= '0;
        norm_a_sum <= '0;
        norm_b_sum <= '0;
      end else begin
        dot_sum    <= dot_sum_next;
        norm_a_sum <= norm_a_sum_next;
        norm_b_sum <= norm_b_sum_next;
      end
    end
  end

  assign push             = s1_valid & s1_last;
  assign push_data.dot    = dot_sum_next;
  assign push_data.norm_a = norm_a_sum_next;
  assign push_data.norm_b = norm_b_sum_next;

endmodule

/* hw/rtl/csu_queue.sv */
// Short queue of finished sums between the front end and the back end.
module csu_queue (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  input  csu_pkg::sums_t             push_data,
  input  logic                       pop,
  output logic                       q_valid,
  output csu_pkg::sums_t             q_data,
  output logic [csu_pkg::QCNT_W-1:0] q_count
);

  csu_pkg::sums_t              entries [csu_pkg::QUEUE_DEPTH];
  logic [csu_pkg::QPTR_W-1:0]  wr_ptr;
  logic [csu_pkg::QPTR_W-1:0]  rd_ptr;
  logic                        do_pop;

  assign q_valid = q_count != '0;
  assign q_data  = entries[rd_ptr];
  assign do_pop  = pop & q_valid;

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr  <= '0;
      rd_ptr  <= '0;
      q_count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == csu_pkg::QPTR_W'(csu_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                         : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == csu_pkg::QPTR_W'(csu_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                         : rd_ptr + 1'b1;
      end
      q_count <= q_count + csu_pkg::QCNT_W'(push) - csu_pkg::QCNT_W'(do_pop);
    end
  end

endmodule

/* hw/rtl/csu_back.sv */
// Back end: square roots, product of roots, division and saturation, with the output register.
module csu_back (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         q_valid,
  input  csu_pkg::sums_t               q_data,
  output logic                         pop,
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [csu_pkg::ELEM_W-1:0]   m_tdata,
  output logic                         m_tuser
);

  localparam logic [csu_pkg::QUOT_W-1:0] POS_MAX = csu_pkg::QUOT_W'((1 << csu_pkg::FRAC_SHIFT) - 1);
  localparam logic [csu_pkg::QUOT_W-1:0] NEG_MAX = csu_pkg::QUOT_W'(1 << csu_pkg::FRAC_SHIFT);

  csu_pkg::back_state_t state;
  csu_pkg::back_state_t state_next;

  logic [csu_pkg::ACC_W-1:0]   rem_a;
  logic [csu_pkg::ACC_W-1:0]   rem_b;
  logic [csu_pkg::ACC_W-1:0]   root_a;
  logic [csu_pkg::ACC_W-1:0]   root_b;
  logic [csu_pkg::ACC_W-1:0]   trial_bit;
  logic [csu_pkg::STEP_W-1:0]  step;
  logic [csu_pkg::ACC_W-1:0]   mag;
  logic                        dot_neg;
  logic                        zero;
  logic                        sat;
  logic [csu_pkg::ACC_W-1:0]   prod;
  logic [csu_pkg::ACC_W-1:0]   rem;
  logic [csu_pkg::QUOT_W-1:0]  quot;
  logic [csu_pkg::ACC_W:0]     div_trial;
  logic [csu_pkg::QUOT_W-1:0]  low_bits;
  logic [csu_pkg::ACC_W-1:0]   sum_a;
  logic [csu_pkg::ACC_W-1:0]   sum_b;
  logic [csu_pkg::ELEM_W-1:0]  sim;
  logic                        out_load;
  logic                        out_valid;

  assign sum_a     = root_a + trial_bit;
  assign sum_b     = root_b + trial_bit;
  assign low_bits  = {mag[1:0], csu_pkg::FRAC_SHIFT'(0)};
  assign div_trial = {rem, low_bits[csu_pkg::QUOT_W-1 - csu_pkg::STEP_W'(step)]};

  always_comb begin
    if (zero) begin
      sim = '0;
    end else if (dot_neg) begin
      sim = (sat || quot > NEG_MAX) ? csu_pkg::ELEM_W'(NEG_MAX)
                                    : csu_pkg::ELEM_W'(-quot);
    end else begin
      sim = (sat || quot > POS_MAX) ? csu_pkg::ELEM_W'(POS_MAX)
                                    : quot[csu_pkg::ELEM_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= csu_pkg::BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    pop        = 1'b0;
    out_load   = 1'b0;
    unique case (state)
      csu_pkg::BK_IDLE: begin
        if (q_valid) begin
          pop = 1'b1;
          if (q_data.norm_a == '0 || q_data.norm_b == '0) begin
            state_next = csu_pkg::BK_DONE;
          end else begin
            state_next = csu_pkg::BK_SQRT;
          end
        end
      end
      csu_pkg::BK_SQRT: begin
        if (step == csu_pkg::STEP_W'(csu_pkg::ROOT_W - 1)) begin
          state_next = csu_pkg::BK_MUL;
        end
      end
      csu_pkg::BK_MUL: begin
        state_next = csu_pkg::BK_CHECK;
      end
      csu_pkg::BK_CHECK: begin
        if ({2'b00, mag} >= {prod, 2'b00}) begin
          state_next = csu_pkg::BK_DONE;
        end else begin
          state_next = csu_pkg::BK_DIV;
        end
      end
      csu_pkg::BK_DIV: begin
        if (step == csu_pkg::STEP_W'(csu_pkg::QUOT_W - 1)) begin
          state_next = csu_pkg::BK_DONE;
        end
      end
      csu_pkg::BK_DONE: begin
        if (!out_valid || m_tready) begin
          out_load   = 1'b1;
          state_next = csu_pkg::BK_IDLE;
        end
      end
      default: begin
        state_next = csu_pkg::BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    case (state)
      csu_pkg::BK_IDLE: begin
        zero      <= q_data.norm_a == '0 || q_data.norm_b == '0;
        sat       <= 1'b0;
        dot_neg   <= q_data.dot[csu_pkg::ACC_W-1];
        mag       <= q_data.dot[csu_pkg::ACC_W-1] ? csu_pkg::ACC_W'(-q_data.dot)
                                                  : csu_pkg::ACC_W'(q_data.dot);
        rem_a     <= q_data.norm_a;
        rem_b     <= q_data.norm_b;
        root_a    <= '0;
        root_b    <= '0;
        trial_bit <= csu_pkg::ACC_W'(1) << (csu_pkg::ACC_W - 2);
        step      <= '0;
      end
      csu_pkg::BK_SQRT: begin
        if (rem_a >= sum_a) begin
          rem_a  <= rem_a - sum_a;
          root_a <= (root_a >> 1) + trial_bit;
        end else begin
          root_a <= root_a >> 1;
        end
        if (rem_b >= sum_b) begin
          rem_b  <= rem_b - sum_b;
          root_b <= (root_b >> 1) + trial_bit;
        end else begin
          root_b <= root_b >> 1;
        end
        trial_bit <= trial_bit >> 2;
        step      <= step + 1'b1;
      end
      csu_pkg::BK_MUL: begin
        prod <= root_a[csu_pkg::ROOT_W-1:0] * root_b[csu_pkg::ROOT_W-1:0];
      end
      csu_pkg::BK_CHECK: begin
        sat  <= {2'b00, mag} >= {prod, 2'b00};
        rem  <= mag >> 2;
        quot <= '0;
        step <= '0;
      end
      csu_pkg::BK_DIV: begin
        if (div_trial >= {1'b0, prod}) begin
          rem  <= csu_pkg::ACC_W'(div_trial - {1'b0, prod});
          quot <= {quot[csu_pkg::QUOT_W-2:0], 1'b1};
        end else begin
          rem  <= div_trial[csu_pkg::ACC_W-1:0];
          quot <= {quot[csu_pkg::QUOT_W-2:0], 1'b0};
        end
        step <= step + 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= sim;
      m_tuser <= zero;
    end
  end

  assign m_tvalid = out_valid;

endmodule

/* hw/rtl/cosine_similarity_unit.sv */
// A vector's last beat passes the product stage into the two-entry sums queue; the back end then
// runs 24-step square roots, their product and a 17-step division, skipping the division when the
// quotient saturates and all of these when a norm is zero; the output register holds the result
// until taken. Throughput: one element pair a cycle into the accumulators while the queue has
// room, so the following vectors stream in while the back end works on earlier ones.
// Reset is synchronous and active high; it clears the accumulators, the queue and the output.
module cosine_similarity_unit #(
  parameter int MAX_DIM = 512
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // element_a [15:0], element_b [31:16]
  input  logic        s_tlast,   // last
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // similarity [15:0]
  output logic        m_tuser    // zero_norm [0]
);

  logic                       push;
  csu_pkg::sums_t             push_data;
  logic                       pop;
  logic                       q_valid;
  csu_pkg::sums_t             q_data;
  logic [csu_pkg::QCNT_W-1:0] q_count;

  csu_front #(
    .MAX_DIM(MAX_DIM)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .q_count   (q_count),
    .push      (push),
    .push_data (push_data)
  );

  csu_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .q_valid   (q_valid),
    .q_data    (q_data),
    .q_count   (q_count)
  );

  csu_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_data   (q_data),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

endmodule

/* hw/rtl/csu_checker.sv */
// Port-level checker for the cosine similarity unit, bound to the top level.
`include "cosine_similarity_unit_assert.svh"

module csu_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [15:0] m_tdata,
  input logic        m_tuser
);

  `CSU_ASSERT_NOW(a_zero_norm_sim, clk, rst, m_tvalid && m_tuser, m_tdata == 16'h0000, "zero norm beat with nonzero similarity")
  `CSU_ASSERT_NEXT(a_out_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled output beat changed")
  `CSU_ASSERT_ALWAYS_NEXT(a_reset_out, clk, rst, !m_tvalid, "output valid just after reset")
  `CSU_ASSERT_ALWAYS_NEXT(a_reset_ready, clk, rst, s_tready, "input not ready just after reset")

endmodule

bind cosine_similarity_unit csu_checker u_csu_checker (.*);

/* tb/cosine_similarity_unit_tb.sv */
// Self-checking testbench for the cosine similarity unit: directed rows, then random vectors.
module cosine_similarity_unit_tb;

  localparam int MAX_PAIRS       = 512;
  localparam int TOTAL_ITEMS     = 1300;
  localparam int WATCHDOG_LIMIT  = 5000;
  localparam int HOLD_AFTER      = 30;
  localparam int HOLD_CYCLES     = 600;
  localparam int DRAIN_CYCLES    = 100;
  localparam int IDLE_PERCENT    = 13;
  localparam int CALM_FIRST      = 400;
  localparam int CALM_LAST       = 700;
  localparam int LONG_VECTOR_NUM = 20;
  localparam logic [csu_pkg::ELEM_W-1:0] SIM_MAX = 16'h7FFF;
  localparam logic [csu_pkg::ELEM_W-1:0] SIM_MIN = 16'h8000;

  typedef struct packed {
    logic [csu_pkg::ELEM_W-1:0] similarity;
    logic                       zero_norm;
  } similarity_t;

  typedef struct packed {
    logic [csu_pkg::ELEM_W-1:0] a;
    logic [csu_pkg::ELEM_W-1:0] b;
    logic                       last;
    logic                       known;
    logic [csu_pkg::ELEM_W-1:0] similarity;
    logic                       zero_norm;
  } pair_row_t;

  typedef enum int {
    VK_RANDOM,
    VK_SMALL,
    VK_ZERO_A,
    VK_ZERO_B,
    VK_SAME,
    VK_OPPOSITE,
    VK_EXTREME
  } vector_kind_t;

  localparam int DIRECTED_ROWS = 22;

  // Rows with the known bit set carry a result that follows directly from the values.
  pair_row_t pair_rows [DIRECTED_ROWS] = '{
    '{16'h0000, 16'h0000, 1'b1, 1'b1, 16'h0000, 1'b1},
    '{16'h7FFF, 16'h7FFF, 1'b1, 1'b1, 16'h7FFF, 1'b0},
    '{16'h8000, 16'h8000, 1'b1, 1'b1, 16'h7FFF, 1'b0},
    '{16'h8000, 16'h7FFF, 1'b1, 1'b1, 16'h8000, 1'b0},
    '{16'h7FFF, 16'h8000, 1'b1, 1'b1, 16'h8000, 1'b0},
    '{16'h0000, 16'h3039, 1'b1, 1'b1, 16'h0000, 1'b1},
    '{16'hFFFF, 16'h0000, 1'b1, 1'b1, 16'h0000, 1'b1},
    '{16'h0001, 16'h0001, 1'b0, 1'b0, 16'h0000, 1'b0},
    '{16'h0001, 16'h0001, 1'b1, 1'b1, 16'h7FFF, 1'b0},
    '{16'h0001, 16'hFFFF, 1'b0, 1'b0, 16'h0000, 1'b0},
    '{16'h0001, 16'hFFFF, 1'b1, 1'b1, 16'h8000, 1'b0},
    '{16'h4000, 16'h0000, 1'b0, 1'b0, 16'h0000, 1'b0},
    '{16'h0000, 16'h4000, 1'b1, 1'b1, 16'h0000, 1'b0},
    '{16'h0003, 16'h0004, 1'b0, 1'b0, 16'h0000, 1'b0},
    '{16'h0005, 16'hFFF4, 1'b0, 1'b0, 16'h0000, 1'b0},
    '{16'hFFF9, 16'h0018, 1'b1, 1'b0, 16'h0000, 1'b0},
    '{16'h5555, 16'hAAAA, 1'b1, 1'b0, 16'h0000, 1'b0},
    '{16'h0064, 16'hFFCE, 1'b0, 1'b0, 16'h0000, 1'b0},
    '{16'hFF38, 16'h012C, 1'b0, 1'b0, 16'h0000, 1'b0},
    '{16'h7FFF, 16'hFFFF, 1'b1, 1'b0, 16'h0000, 1'b0},
    '{16'h0001, 16'h7FFF, 1'b1, 1'b1, 16'h7FFF, 1'b0},
    '{16'h1234, 16'hEDCC, 1'b1, 1'b0, 16'h0000, 1'b0}
  };

  logic                       clk      = 1'b0;
  logic                       rst      = 1'b1;
  logic                       s_tvalid = 1'b0;
  logic                       s_tready;
  logic [31:0]                s_tdata  = '0;
  logic                       s_tlast  = 1'b0;
  logic                       m_tvalid;
  logic                       m_tready = 1'b0;
  logic [csu_pkg::ELEM_W-1:0] m_tdata;
  logic                       m_tuser;

  logic signed [csu_pkg::ACC_W-1:0] dot_acc;
  logic signed [csu_pkg::ACC_W-1:0] norm_a_acc;
  logic signed [csu_pkg::ACC_W-1:0] norm_b_acc;
  int unsigned                      pairs_taken;

  similarity_t expected_similarities [$];
  int          mismatches   = 0;
  int          items_sent   = 0;
  int          quiet_cycles = 0;
  bit          calm         = 1'b0;

  cosine_similarity_unit #(
    .MAX_DIM(MAX_PAIRS)
  ) DUT (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tlast (s_tlast),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser)
  );

  always #5 clk = ~clk;

  function automatic longint unsigned floor_root(input longint unsigned n);
    longint unsigned root;
    longint unsigned trial;
    root = 0;
    for (int k = 31; k >= 0; k--) begin
      trial = root | (64'd1 << k);
      if (trial * trial <= n) root = trial;
    end
    return root;
  endfunction

  function automatic bit accumulate_and_score(input logic signed [csu_pkg::ELEM_W-1:0] a,
                                              input logic signed [csu_pkg::ELEM_W-1:0] b,
                                              input logic last,
                                              output similarity_t score);
    longint          dot_wide;
    longint unsigned mag;
    longint unsigned quot;
    longint unsigned neg_quot;
    score = '0;
    if (pairs_taken < MAX_PAIRS) begin
      dot_acc    = dot_acc + a * b;
      norm_a_acc = norm_a_acc + a * a;
      norm_b_acc = norm_b_acc + b * b;
      pairs_taken++;
    end
    if (!last) return 1'b0;
    if (norm_a_acc == 0 || norm_b_acc == 0) begin
      score.zero_norm = 1'b1;
    end else begin
      dot_wide = dot_acc;
      mag      = (dot_wide < 0) ? -dot_wide : dot_wide;
      quot     = (mag << csu_pkg::FRAC_SHIFT) /
                 (floor_root(64'(norm_a_acc)) * floor_root(64'(norm_b_acc)));
      if (dot_wide < 0) begin
        neg_quot         = 64'd0 - quot;
        score.similarity = (quot > 64'(SIM_MIN)) ? SIM_MIN
                                                 : neg_quot[csu_pkg::ELEM_W-1:0];
      end else begin
        score.similarity = (quot > 64'(SIM_MAX)) ? SIM_MAX : quot[csu_pkg::ELEM_W-1:0];
      end
    end
    dot_acc     = '0;
    norm_a_acc  = '0;
    norm_b_acc  = '0;
    pairs_taken = 0;
    return 1'b1;
  endfunction

  function automatic logic [csu_pkg::ELEM_W-1:0] pick_element(input vector_kind_t kind);
    logic [csu_pkg::ELEM_W-1:0] value;
    value = csu_pkg::ELEM_W'($urandom());
    case (kind)
      VK_SMALL: begin
        value = csu_pkg::ELEM_W'($urandom_range(0, 64) - 32);
      end
      VK_EXTREME: begin
        case ($urandom_range(3))
          0: value = 16'h8000;
          1: value = 16'h7FFF;
          2: value = 16'h0001;
          default: value = 16'hFFFF;
        endcase
      end
      default: ;
    endcase
    return value;
  endfunction

  task automatic offer_pair(input logic [csu_pkg::ELEM_W-1:0] a,
                            input logic [csu_pkg::ELEM_W-1:0] b,
                            input logic last, input logic known, input similarity_t known_score);
    similarity_t score;
    while (!calm && $urandom_range(99) < IDLE_PERCENT) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {b, a};
    s_tlast  <= last;
    do @(posedge clk); while (!s_tready);
    if (accumulate_and_score(a, b, last, score))
      expected_similarities.push_back(known ? known_score : score);
    items_sent++;
    calm = (items_sent >= CALM_FIRST) && (items_sent < CALM_LAST);
  endtask

  initial begin : stimulus
    vector_kind_t               kind;
    int                         len;
    int                         vectors_sent;
    int                         pick;
    logic [csu_pkg::ELEM_W-1:0] ea;
    logic [csu_pkg::ELEM_W-1:0] eb;
    dot_acc      = '0;
    norm_a_acc   = '0;
    norm_b_acc   = '0;
    pairs_taken  = 0;
    vectors_sent = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    foreach (pair_rows[i])
      offer_pair(pair_rows[i].a, pair_rows[i].b, pair_rows[i].last, pair_rows[i].known,
                 {pair_rows[i].similarity, pair_rows[i].zero_norm});
    while (items_sent < TOTAL_ITEMS) begin
      pick = $urandom_range(99);
      if (pick < 40) kind = VK_RANDOM;
      else if (pick < 55) kind = VK_SMALL;
      else if (pick < 63) kind = VK_ZERO_A;
      else if (pick < 71) kind = VK_ZERO_B;
      else if (pick < 81) kind = VK_SAME;
      else if (pick < 91) kind = VK_OPPOSITE;
      else kind = VK_EXTREME;
      pick = $urandom_range(99);
      if (pick < 70) len = $urandom_range(1, 8);
      else if (pick < 95) len = $urandom_range(9, 40);
      else len = $urandom_range(41, 120);
      // One vector runs past the accumulation limit, with extreme values (full-scale and unit magnitudes).
      if (vectors_sent == LONG_VECTOR_NUM) begin
        len  = $urandom_range(MAX_PAIRS + 1, MAX_PAIRS + 28);
        kind = VK_EXTREME;
      end
      for (int n = 0; n < len; n++) begin
        ea = (kind == VK_ZERO_A) ? '0 : pick_element(kind);
        case (kind)
          VK_SAME:     eb = ea;
          VK_OPPOSITE: eb = -ea;
          VK_ZERO_B:   eb = '0;
          default:     eb = pick_element(kind);
        endcase
        offer_pair(ea, eb, n == len - 1, 1'b0, '0);
      end
      vectors_sent++;
    end
    s_tvalid <= 1'b0;
    while (expected_similarities.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_similarities.size() != 0) begin
      $error("%0d results never arrived", expected_similarities.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin : result_side
    int          taken;
    int          hold_left;
    bit          held;
    similarity_t wanted;
    taken     = 0;
    hold_left = 0;
    held      = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && m_tvalid && m_tready) begin
        taken++;
        if (expected_similarities.size() == 0) begin
          $error("result beat with no expectation: similarity %0d, zero_norm %0b",
                 $signed(m_tdata), m_tuser);
          mismatches++;
        end else begin
          wanted = expected_similarities.pop_front();
          if (m_tdata !== wanted.similarity) begin
            $error("similarity: expected %0d, got %0d", $signed(wanted.similarity),
                   $signed(m_tdata));
            mismatches++;
          end
          if (m_tuser !== wanted.zero_norm) begin
            $error("zero_norm: expected %0b, got %0b", wanted.zero_norm, m_tuser);
            mismatches++;
          end
        end
      end
      // A single long hold-off lets the sums queue fill and stall the input side.
      if (taken == HOLD_AFTER && !held) begin
        held      = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= calm || ($urandom_range(99) >= IDLE_PERCENT);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule
